// ===== rtl/core/chs_pkg.sv =====
// Shared constants, types and the sequencer's control store for the
// sector transfer splitter. No dependencies.
package chs_pkg;

  // Field widths
  localparam int START_W    = 24;
  localparam int REQ_W      = 7;
  localparam int ADDR_W     = 20;
  localparam int SPT_W      = 6;
  localparam int HEADS_W    = 9;
  localparam int CYL_W      = 10;
  localparam int HEAD_W     = 8;
  localparam int CUR_CYL_W  = 15;
  localparam int PER_CYL_W  = SPT_W + HEADS_W;

  // Geometry and transfer constants
  localparam int SECTOR_BYTES_LOG2 = 9;
  localparam int PAGE_LOG2         = 16;
  localparam int MAX_REQUEST_DEF   = 64;
  localparam logic [SPT_W-1:0]     SPT_RESET   = SPT_W'(18);
  localparam logic [HEADS_W-1:0]   HEADS_RESET = HEADS_W'(2);
  localparam logic [HEADS_W-1:0]   HEADS_MAX   = HEADS_W'(256);
  localparam logic [CUR_CYL_W-1:0] CYL_LIMIT   = CUR_CYL_W'(1024);

  // APB register map: register index is paddr[2]
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_SPT   = 1'b0;
  localparam logic REG_HEADS = 1'b1;

  // Iterative divider
  localparam int DIV_CNT_W      = 5;
  localparam int DIV_CYL_STEPS  = START_W;
  localparam int DIV_HEAD_STEPS = PER_CYL_W;

  // Sequencer step addresses
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_IDLE       = 3'd0;
  localparam logic [STEP_W-1:0] ST_MUL        = 3'd1;
  localparam logic [STEP_W-1:0] ST_CYL_INIT   = 3'd2;
  localparam logic [STEP_W-1:0] ST_CYL_LOOP   = 3'd3;
  localparam logic [STEP_W-1:0] ST_HEAD_INIT  = 3'd4;
  localparam logic [STEP_W-1:0] ST_HEAD_LOOP  = 3'd5;
  localparam logic [STEP_W-1:0] ST_CHS        = 3'd6;
  localparam logic [STEP_W-1:0] ST_EMIT       = 3'd7;

  // Datapath operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_LOAD      = 3'd0;
  localparam logic [OP_W-1:0] OP_MUL       = 3'd1;
  localparam logic [OP_W-1:0] OP_CYL_INIT  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV_STEP  = 3'd3;
  localparam logic [OP_W-1:0] OP_HEAD_INIT = 3'd4;
  localparam logic [OP_W-1:0] OP_CHS       = 3'd5;
  localparam logic [OP_W-1:0] OP_EMIT      = 3'd6;

  // Branch conditions
  localparam int CND_W = 3;
  localparam logic [CND_W-1:0] CND_NEXT     = 3'd0;
  localparam logic [CND_W-1:0] CND_WAIT_IN  = 3'd1;
  localparam logic [CND_W-1:0] CND_DIV_BUSY = 3'd2;
  localparam logic [CND_W-1:0] CND_IF_EMPTY = 3'd3;
  localparam logic [CND_W-1:0] CND_EMIT     = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CND_W-1:0]  cond;
    logic [STEP_W-1:0] target;
  } ucode_word_t;

  // Control store: one word per step
  function automatic ucode_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_word_t w;
    case (step)
      ST_IDLE:      w = '{op: OP_LOAD,      cond: CND_WAIT_IN,  target: ST_IDLE};
      ST_MUL:       w = '{op: OP_MUL,       cond: CND_NEXT,     target: ST_IDLE};
      ST_CYL_INIT:  w = '{op: OP_CYL_INIT,  cond: CND_NEXT,     target: ST_IDLE};
      ST_CYL_LOOP:  w = '{op: OP_DIV_STEP,  cond: CND_DIV_BUSY, target: ST_CYL_LOOP};
      ST_HEAD_INIT: w = '{op: OP_HEAD_INIT, cond: CND_NEXT,     target: ST_IDLE};
      ST_HEAD_LOOP: w = '{op: OP_DIV_STEP,  cond: CND_DIV_BUSY, target: ST_HEAD_LOOP};
      ST_CHS:       w = '{op: OP_CHS,       cond: CND_IF_EMPTY, target: ST_IDLE};
      ST_EMIT:      w = '{op: OP_EMIT,      cond: CND_EMIT,     target: ST_EMIT};
      default:      w = '{op: OP_LOAD,      cond: CND_WAIT_IN,  target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/chs_if.sv =====
// Request and chunk channel interfaces (valid/ready with payload).
// Depends on chs_pkg for field widths.
interface chs_req_if import chs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [START_W-1:0] start_sector;
  logic [REQ_W-1:0]   request_sectors;
  logic [ADDR_W-1:0]  buffer_address;
  logic               is_write;

  modport source (output valid, start_sector, request_sectors, buffer_address, is_write,
                  input ready);
  modport sink   (input valid, start_sector, request_sectors, buffer_address, is_write,
                  output ready);
endinterface

interface chs_chunk_if import chs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CYL_W-1:0]  cylinder;
  logic [HEAD_W-1:0] head;
  logic [SPT_W-1:0]  sector;
  logic [SPT_W-1:0]  chunk_sectors;
  logic [ADDR_W-1:0] dma_address;
  logic              use_bounce;
  logic              write_op;
  logic              cylinder_overflow;
  logic              last;

  modport source (output valid, cylinder, head, sector, chunk_sectors, dma_address,
                  use_bounce, write_op, cylinder_overflow, last,
                  input ready);
  modport sink   (input valid, cylinder, head, sector, chunk_sectors, dma_address,
                  use_bounce, write_op, cylinder_overflow, last,
                  output ready);
endinterface

// ===== rtl/core/chs_transfer_splitter.sv =====
// Sector transfer splitter top level: microcoded sequencer, divider and chunk datapath.
// Depends on chs_pkg and the channel interfaces in chs_if.sv.
//
// One request transaction is taken at a time. After acceptance the block converts the
// start sector: it first forms sectors-per-cylinder, then a shared restoring divider
// retires one quotient bit per cycle, first for the cylinder and then for the head and
// sector, with a set-up step before each division and one that captures head and sector.
// After that one chunk transaction is produced per cycle while the sink keeps up; a
// zero-length request returns to idle after the conversion. Results wait in an output
// register, so the next request can be accepted while the final chunk is still pending.
// Geometry is set through the APB port (sectors per track at 0x0, heads at 0x4)
// and must only be written while the block is idle.
module chs_transfer_splitter import chs_pkg::*; #(
  parameter int MAX_REQUEST = MAX_REQUEST_DEF
) (
  input  logic               clk,
  input  logic               rst,
  chs_req_if.sink            req,
  chs_chunk_if.source        chunk,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int REM_W = $clog2(MAX_REQUEST + 1);
  localparam int END_W = ADDR_W + 1;

  // Configuration registers
  logic [SPT_W-1:0]   spt;
  logic [HEADS_W-1:0] heads;
  logic [SPT_W-1:0]   spt_eff;
  logic [HEADS_W-1:0] heads_eff;

  // Sequencer
  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_next;
  ucode_word_t        uw;

  // Divider
  logic [START_W-1:0]   div_quo;
  logic [PER_CYL_W-1:0] div_rem;
  logic [PER_CYL_W-1:0] div_den;
  logic [DIV_CNT_W-1:0] div_count;
  logic [PER_CYL_W:0]   div_shift;
  logic [PER_CYL_W+1:0] div_diff;
  logic                 div_bit;
  logic [PER_CYL_W-1:0] per_cyl;

  // Transfer position
  logic [CUR_CYL_W-1:0] cur_cylinder;
  logic [HEAD_W-1:0]    cur_head;
  logic [SPT_W-1:0]     cur_sector;
  logic [REM_W-1:0]     remaining;
  logic [ADDR_W-1:0]    cur_address;
  logic                 cyl_high;
  logic                 wr;

  // Chunk datapath
  logic [END_W-1:0]      end_sum;
  logic                  page_cross;
  logic [PAGE_LOG2:0]    page_room;
  logic [7:0]            size_want;
  logic [SPT_W-1:0]      track_room;
  logic [SPT_W-1:0]      size_fit;
  logic                  bounce;
  logic [SPT_W-1:0]      size;
  logic [REM_W-1:0]      remaining_after;
  logic [SPT_W:0]        sec_sum;
  logic [HEADS_W-1:0]    head_inc;
  logic [CUR_CYL_W-1:0]  cyl_inc;

  // Handshakes
  logic req_fire;
  logic out_block;
  logic emit_fire;
  logic cfg_write;

  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      spt   <= SPT_RESET;
      heads <= HEADS_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_SPT:   spt   <= pwdata[SPT_W-1:0];
        REG_HEADS: heads <= pwdata[HEADS_W-1:0];
        default:   spt   <= spt;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SPT:   prdata = PDATA_W'(spt);
      REG_HEADS: prdata = PDATA_W'(heads);
      default:   prdata = '0;
    endcase
  end

  // Zero geometry acts as one; heads are capped at 256
  assign spt_eff   = (spt == '0) ? SPT_W'(1) : spt;
  assign heads_eff = (heads == '0) ? HEADS_W'(1) : ((heads > HEADS_MAX) ? HEADS_MAX : heads);

  // Control store fetch and handshakes
  assign uw        = ucode_rom(step);
  assign req.ready = (step == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_block = chunk.valid && !chunk.ready;
  assign emit_fire = (uw.op == OP_EMIT) && !out_block;

  // Next step: fall through or branch on the word's condition
  always_comb begin
    case (uw.cond)
      CND_WAIT_IN:  step_next = req_fire ? step + STEP_W'(1) : step;
      CND_DIV_BUSY: step_next = (div_count != DIV_CNT_W'(1)) ? uw.target : step + STEP_W'(1);
      CND_IF_EMPTY: step_next = (remaining == '0) ? uw.target : step + STEP_W'(1);
      CND_EMIT:     step_next = (out_block || remaining_after != '0) ? uw.target
                                                                      : step + STEP_W'(1);
      default:      step_next = step + STEP_W'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Restoring divide step: one quotient bit per cycle
  assign div_shift = {div_rem, div_quo[START_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, div_den};
  assign div_bit   = !div_diff[PER_CYL_W+1];

  // Chunk size: page limit, then track limit, then bounce fallback
  assign end_sum    = END_W'(cur_address) + END_W'({remaining, {SECTOR_BYTES_LOG2{1'b0}}});
  assign page_cross = end_sum[END_W-1:PAGE_LOG2] != {1'b0, cur_address[ADDR_W-1:PAGE_LOG2]};
  assign page_room  = (PAGE_LOG2+1)'(1 << PAGE_LOG2) - {1'b0, cur_address[PAGE_LOG2-1:0]};
  assign size_want  = page_cross ? 8'(page_room[PAGE_LOG2:SECTOR_BYTES_LOG2]) : 8'(remaining);
  assign track_room = spt_eff - cur_sector;
  assign size_fit   = (size_want > 8'(track_room)) ? track_room : size_want[SPT_W-1:0];
  assign bounce     = (size_fit == '0) || (cur_address[0] && remaining == REM_W'(1));
  assign size       = bounce ? SPT_W'(1) : size_fit;
  assign remaining_after = remaining - REM_W'(size);

  // Position advance
  assign sec_sum  = {1'b0, cur_sector} + {1'b0, size};
  assign head_inc = {1'b0, cur_head} + HEADS_W'(1);
  assign cyl_inc  = cur_cylinder + CUR_CYL_W'(1);

  // Datapath driven by the current control word
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_LOAD: begin
        if (req_fire) begin
          div_quo     <= req.start_sector;
          cur_address <= req.buffer_address;
          wr          <= req.is_write;
          if (int'(req.request_sectors) > MAX_REQUEST) begin
            remaining <= REM_W'(MAX_REQUEST);
          end else begin
            remaining <= REM_W'(req.request_sectors);
          end
        end
      end
      OP_MUL: begin
        per_cyl <= PER_CYL_W'(spt_eff) * PER_CYL_W'(heads_eff);
      end
      OP_CYL_INIT: begin
        div_rem   <= '0;
        div_den   <= per_cyl;
        div_count <= DIV_CNT_W'(DIV_CYL_STEPS);
      end
      OP_DIV_STEP: begin
        div_quo   <= {div_quo[START_W-2:0], div_bit};
        div_rem   <= div_bit ? div_diff[PER_CYL_W-1:0] : div_shift[PER_CYL_W-1:0];
        div_count <= div_count - DIV_CNT_W'(1);
      end
      OP_HEAD_INIT: begin
        // Quotient is the cylinder; remainder is divided again by the track size
        cur_cylinder <= div_quo[CUR_CYL_W-1:0];
        cyl_high     <= |div_quo[START_W-1:CYL_W];
        div_quo      <= {div_rem, {(START_W-PER_CYL_W){1'b0}}};
        div_rem      <= '0;
        div_den      <= PER_CYL_W'(spt_eff);
        div_count    <= DIV_CNT_W'(DIV_HEAD_STEPS);
      end
      OP_CHS: begin
        cur_head   <= div_quo[HEAD_W-1:0];
        cur_sector <= div_rem[SPT_W-1:0];
      end
      OP_EMIT: begin
        if (emit_fire) begin
          remaining   <= remaining_after;
          cur_address <= cur_address +
                         ADDR_W'({size, {SECTOR_BYTES_LOG2{1'b0}}});
          if (sec_sum >= {1'b0, spt_eff}) begin
            cur_sector <= '0;
            if (head_inc >= heads_eff) begin
              cur_head     <= '0;
              cur_cylinder <= cyl_inc;
              if (cyl_inc == CYL_LIMIT) begin
                cyl_high <= 1'b1;
              end
            end else begin
              cur_head <= head_inc[HEAD_W-1:0];
            end
          end else begin
            cur_sector <= sec_sum[SPT_W-1:0];
          end
        end
      end
      default: begin
        per_cyl <= per_cyl;
      end
    endcase
  end

  // Output register: valid is control, payload loads on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk.valid <= 1'b0;
    end else if (emit_fire) begin
      chunk.valid <= 1'b1;
    end else if (chunk.ready) begin
      chunk.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      chunk.cylinder          <= cur_cylinder[CYL_W-1:0];
      chunk.head              <= cur_head;
      chunk.sector            <= cur_sector + SPT_W'(1);
      chunk.chunk_sectors     <= size;
      chunk.dma_address       <= cur_address;
      chunk.use_bounce        <= bounce;
      chunk.write_op          <= wr;
      chunk.cylinder_overflow <= cyl_high;
      chunk.last              <= (remaining_after == '0);
    end
  end

  // Checks
  a_chunk_nonzero: assert property (@(posedge clk) disable iff (rst)
    chunk.valid |-> chunk.chunk_sectors != '0)
    else $error("chunk transaction with zero sectors");

  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    step == ST_EMIT |-> remaining != '0)
    else $error("emission step entered with nothing remaining");

  a_div_count_live: assert property (@(posedge clk) disable iff (rst)
    uw.op == OP_DIV_STEP |-> div_count != '0)
    else $error("divider stepped with exhausted count");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && remaining_after == '0) |=> step == ST_IDLE)
    else $error("sequencer did not return to idle after final chunk");

endmodule

// ===== bench/chs_chunk_checker.sv =====
// Checker for the sector transfer splitter: follows the geometry writes on the APB
// port, predicts the chunk transactions of every accepted request and compares them.
// Depends on chs_pkg and the channel interfaces in chs_if.sv.
module chs_chunk_checker import chs_pkg::*; #(
  parameter int MAX_REQUEST = MAX_REQUEST_DEF
) (
  input  logic               clk,
  input  logic               rst,
  chs_req_if                 req,
  chs_chunk_if               chunk,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 pending,
  output int                 fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CYL_W-1:0]  cylinder;
    logic [HEAD_W-1:0] head;
    logic [SPT_W-1:0]  sector;
    logic [SPT_W-1:0]  chunk_sectors;
    logic [ADDR_W-1:0] dma_address;
    logic              use_bounce;
    logic              write_op;
    logic              cylinder_overflow;
    logic              last;
  } chunk_t;

  // Geometry as last written over APB
  logic [SPT_W-1:0]   spt_cfg;
  logic [HEADS_W-1:0] heads_cfg;

  chunk_t due_chunks[$];
  chunk_t got;
  chunk_t want;
  int     failures = 0;

  // Walk one request through the geometry and queue the chunks it yields
  task automatic split_request(input logic [START_W-1:0] start,
                               input logic [REQ_W-1:0]   count,
                               input logic [ADDR_W-1:0]  buf_addr,
                               input logic               wr);
    int unsigned          spt, heads, per_cyl, cyl, track_off;
    int unsigned          head_pos, sec_pos, left, addr, size, span_end;
    logic [CUR_CYL_W-1:0] cyl_pos;
    logic                 over;
    logic                 bounce;
    chunk_t               c;
    spt       = (spt_cfg == 0) ? 1 : spt_cfg;
    heads     = (heads_cfg == 0) ? 1 : ((heads_cfg > HEADS_MAX) ? HEADS_MAX : heads_cfg);
    per_cyl   = spt * heads;
    cyl       = start / per_cyl;
    track_off = start % per_cyl;
    cyl_pos   = CUR_CYL_W'(cyl);
    over      = (cyl > 1023);
    head_pos  = track_off / spt;
    sec_pos   = track_off % spt;
    left      = (count > MAX_REQUEST) ? MAX_REQUEST : count;
    addr      = buf_addr;
    while (left != 0) begin
      // limit by the 64 KiB page, then by the end of the track
      size     = left;
      span_end = addr + (left << SECTOR_BYTES_LOG2);
      if (((span_end ^ addr) >> PAGE_LOG2) != 0)
        size = ((1 << PAGE_LOG2) - (addr % (1 << PAGE_LOG2))) >> SECTOR_BYTES_LOG2;
      if (size > spt - sec_pos)
        size = spt - sec_pos;
      // no whole sector fits, or a lone final sector at an odd address
      bounce = (size == 0) || (addr[0] && left == 1);
      if (bounce)
        size = 1;
      left -= size;
      c.cylinder          = cyl_pos[CYL_W-1:0];
      c.head              = HEAD_W'(head_pos);
      c.sector            = SPT_W'(sec_pos + 1);
      c.chunk_sectors     = SPT_W'(size);
      c.dma_address       = ADDR_W'(addr);
      c.use_bounce        = bounce;
      c.write_op          = wr;
      c.cylinder_overflow = over;
      c.last              = (left == 0);
      due_chunks.push_back(c);
      // advance buffer address and disk position
      addr = (addr + (size << SECTOR_BYTES_LOG2)) % (1 << ADDR_W);
      sec_pos += size;
      if (sec_pos >= spt) begin
        sec_pos = 0;
        head_pos++;
        if (head_pos >= heads) begin
          head_pos = 0;
          cyl_pos  = cyl_pos + 1'b1;
          if (cyl_pos == CYL_LIMIT)
            over = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      spt_cfg   = SPT_RESET;
      heads_cfg = HEADS_RESET;
      due_chunks.delete();
    end else begin
      // geometry register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SPT)
          spt_cfg = pwdata[SPT_W-1:0];
        else
          heads_cfg = pwdata[HEADS_W-1:0];
      end

      if (req.valid && req.ready)
        split_request(req.start_sector, req.request_sectors, req.buffer_address,
                      req.is_write);

      // compare each chunk transaction with the oldest prediction
      if (chunk.valid && chunk.ready) begin
        got = '{cylinder: chunk.cylinder, head: chunk.head, sector: chunk.sector,
                chunk_sectors: chunk.chunk_sectors, dma_address: chunk.dma_address,
                use_bounce: chunk.use_bounce, write_op: chunk.write_op,
                cylinder_overflow: chunk.cylinder_overflow, last: chunk.last};
        if (due_chunks.size() == 0) begin
          if (failures < 10)
            $display("%0t: chunk with nothing outstanding: cyl=%0d head=%0d sec=%0d n=%0d",
                     $realtime, got.cylinder, got.head, got.sector, got.chunk_sectors);
          failures++;
        end else begin
          want = due_chunks.pop_front();
          if (got !== want) begin
            if (failures < 10) begin
              $display("%0t: chunk mismatch", $realtime);
              $display("  expected cyl=%0d head=%0d sec=%0d n=%0d addr=%05h bnc=%0d wr=%0d ovf=%0d last=%0d",
                       want.cylinder, want.head, want.sector, want.chunk_sectors,
                       want.dma_address, want.use_bounce, want.write_op,
                       want.cylinder_overflow, want.last);
              $display("  actual   cyl=%0d head=%0d sec=%0d n=%0d addr=%05h bnc=%0d wr=%0d ovf=%0d last=%0d",
                       got.cylinder, got.head, got.sector, got.chunk_sectors,
                       got.dma_address, got.use_bounce, got.write_op,
                       got.cylinder_overflow, got.last);
            end
            failures++;
          end
        end
      end
    end
    pending    <= due_chunks.size();
    fail_count <= failures;
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the bench for the sector transfer splitter: clock, reset, request and
// geometry stimulus, chunk back-pressure, watchdog and verdict.
// Depends on chs_pkg, chs_if.sv, the block itself and chs_chunk_checker.
module testbench import chs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int SETTLE_CYCLES   = 60;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 5000;

  // raw register values per phase; zero and oversized heads exercise the clamping
  localparam int PHASE_SPT   [PHASES] = '{18, 1, 63, 0, 63, 9, 1, 63, 17};
  localparam int PHASE_HEADS [PHASES] = '{2, 1, 256, 0, 511, 16, 256, 1, 300};

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int          pending;
  int          fail_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_ticket;
  int unsigned geo_spt;
  int unsigned geo_per_cyl;

  chs_req_if   req_ch();
  chs_chunk_if chunk_ch();

  chs_transfer_splitter u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .chunk   (chunk_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  chs_chunk_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .chunk      (chunk_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one request transaction, with random idle cycles in front
  task automatic offer_request(input logic [START_W-1:0] start,
                               input logic [REQ_W-1:0]   count,
                               input logic [ADDR_W-1:0]  addr,
                               input logic               wr);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.start_sector    <= start;
    req_ch.request_sectors <= count;
    req_ch.buffer_address  <= addr;
    req_ch.is_write        <= wr;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Random request, biased towards page edges, odd buffers and cylinder limits
  task automatic offer_random_request();
    logic [START_W-1:0] start;
    logic [REQ_W-1:0]   count;
    logic [ADDR_W-1:0]  addr;
    int unsigned        pick;
    pick = $urandom_range(99);
    if (pick < 6)
      count = '0;
    else if (pick < 14)
      count = REQ_W'($urandom_range(127, 65));
    else if (pick < 40)
      count = REQ_W'($urandom_range(4, 1));
    else
      count = REQ_W'($urandom_range(64, 5));
    pick = $urandom_range(99);
    if (pick < 35)
      addr = ADDR_W'($urandom());
    else if (pick < 70)
      addr = ADDR_W'(($urandom() & 32'hF0000) | (32'h10000 - $urandom_range(12288, 1)));
    else if (pick < 85)
      addr = ADDR_W'($urandom() & 32'hFFE00);
    else
      addr = ADDR_W'($urandom() | 1);
    pick = $urandom_range(99);
    if (pick < 45)
      start = START_W'($urandom());
    else if (pick < 75)
      start = START_W'($urandom_range(4 * geo_per_cyl - 1, 0));
    else if (pick < 90)
      start = START_W'(1024 * geo_per_cyl - $urandom_range(2 * geo_spt, 1));
    else
      start = START_W'(32768 * geo_per_cyl - $urandom_range(2 * geo_spt, 1));
    offer_request(start, count, addr, 1'($urandom_range(1, 0)));
  endtask

  // Stop offering and wait for every predicted chunk to come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Setup phase, access phase held until pready, then the bus returns to idle
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program the geometry; upper data bits carry junk the block must ignore
  task automatic set_geometry(input int spt, input int heads);
    int unsigned spt_eff;
    int unsigned heads_eff;
    apb_write({REG_SPT, 2'b00}, ($urandom() & 32'hFFFF_FFC0) | spt);
    apb_write({REG_HEADS, 2'b00}, ($urandom() & 32'hFFFF_FE00) | heads);
    spt_eff     = (spt == 0) ? 1 : spt;
    heads_eff   = (heads == 0) ? 1 : ((heads > 256) ? 256 : heads);
    geo_spt     = spt_eff;
    geo_per_cyl = spt_eff * heads_eff;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct <= receiver_pct;
  endtask

  // Chunk receiver: random stalls, plus a long hold whenever one is requested
  initial begin
    int holds_done;
    holds_done = 0;
    chunk_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != holds_done) begin
        holds_done = hold_ticket;
        chunk_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      chunk_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: too long without any transaction on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (chunk_ch.valid && chunk_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Main stimulus
  initial begin
    rst                    <= 1'b1;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    req_ch.valid           <= 1'b0;
    req_ch.start_sector    <= '0;
    req_ch.request_sectors <= '0;
    req_ch.buffer_address  <= '0;
    req_ch.is_write        <= 1'b0;
    hold_ticket            <= 0;
    geo_spt                = 18;
    geo_per_cyl            = 36;
    set_idling(7, 52);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed requests on the reset geometry (18 sectors, 2 heads)
    offer_request(24'd0, 7'd0, 20'h00000, 1'b0);        // zero length: no chunks
    offer_request(24'd0, 7'd1, 20'h00000, 1'b0);
    offer_request(24'd0, 7'd64, 20'h00000, 1'b1);       // track-limited chunks
    offer_request(24'd5, 7'd127, 20'h12345, 1'b0);      // oversized, cut to the maximum
    offer_request(24'd10, 7'd65, 20'h20000, 1'b1);
    offer_request(24'd3, 7'd1, 20'h00401, 1'b0);        // lone sector at odd address
    offer_request(24'd17, 7'd2, 20'h00001, 1'b0);       // odd final sector bounced
    offer_request(24'd0, 7'd5, 20'h00003, 1'b1);        // odd buffer, no bounce needed
    offer_request(24'd0, 7'd4, 20'h0FF00, 1'b0);        // no whole sector before page
    offer_request(24'd0, 7'd6, 20'h0FE00, 1'b1);        // one sector before page
    offer_request(24'd0, 7'd4, 20'hFFE00, 1'b0);        // wrap past top of memory
    offer_request(24'd0, 7'd2, 20'hFFFFF, 1'b1);        // wrap at odd address
    offer_request(24'hFFFFFF, 7'd64, 20'hFFFFF, 1'b1);  // everything at its maximum
    offer_request(24'd36862, 7'd4, 20'h40000, 1'b0);    // runs into cylinder 1024
    offer_request(24'd1179647, 7'd3, 20'h50000, 1'b1);  // cylinder counter wraps
    offer_request(24'd100, 7'd64, 20'h0F001, 1'b1);     // odd buffer across a page
    offer_request(24'hAAAAAA, 7'h55, 20'h55555, 1'b0);
    offer_request(24'h555555, 7'h2A, 20'hAAAAA, 1'b1);
    offer_request(24'd35, 7'd1, 20'h0FFFF, 1'b0);
    offer_request(24'd40000, 7'd33, 20'h7FC00, 1'b1);

    // Random phases over several geometries and idling patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      set_geometry(PHASE_SPT[ph], PHASE_HEADS[ph]);
      if (ph < 3)
        set_idling(7, 52);
      else if (ph < 6)
        set_idling(52, 7);
      else
        set_idling(0, 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ((ph == 1 || ph == 7) && k == 10)
          hold_ticket <= hold_ticket + 1;
        if (ph == 4 && k == 20)
          wait_drained();
        offer_random_request();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
